// ===== hdl/mandelbrot_escape_iteration_macros.svh =====
// Assertion macros for the Mandelbrot escape-time block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MANDELBROT_ESCAPE_ITERATION_MACROS_SVH
`define MANDELBROT_ESCAPE_ITERATION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mbe_pkg.sv =====
// Shared constants, register codes and the iteration cell record for the
// Mandelbrot escape-time block. No dependencies.
package mbe_pkg;

	localparam int FRAC_BITS = 28;
	localparam int C_W       = 32;
	localparam int MAX_W     = 10;
	localparam int CNT_W     = MAX_W + 1;
	localparam int COLOR_W   = 24;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int NUM_CELLS = 2;

	// z stays within about +/-(2^(FRAC_BITS+2) + |c|), so two bits over c suffice.
	localparam int Z_W = (C_W + 2 > FRAC_BITS + 6) ? C_W + 2 : FRAC_BITS + 6;
	// Multiplier operand width once both components are known to be at most 2.
	localparam int N_W = FRAC_BITS + 3;
	localparam int P_W = 2 * N_W;

	localparam logic [Z_W-1:0] Z_LIMIT = Z_W'(1) << (FRAC_BITS + 1);
	localparam logic [P_W:0]   SQ_FOUR = (P_W + 1)'(1) << (2 * FRAC_BITS + 2);

	localparam logic [1:0] REG_MAX_ITERATIONS = 2'd0;
	localparam logic [1:0] REG_INSIDE_COLOR   = 2'd1;
	localparam logic [1:0] REG_OUTSIDE_COLOR  = 2'd2;

	localparam logic [MAX_W-1:0]   MAX_ITER_RESET      = MAX_W'(100);
	localparam logic [COLOR_W-1:0] INSIDE_COLOR_RESET  = 24'hFF_FFFF;
	localparam logic [COLOR_W-1:0] OUTSIDE_COLOR_RESET = 24'h00_0000;

	typedef struct packed {
		logic                  valid;
		logic                  done;
		logic [CNT_W-1:0]      count;
		logic signed [Z_W-1:0] zr;
		logic signed [Z_W-1:0] zi;
	} cell_t;

endpackage

// ===== hdl/mbe_point_if.sv =====
// Input channel of the Mandelbrot escape-time block: one point c per beat.
// Depends on mbe_pkg.
interface mbe_point_if;
	import mbe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [C_W-1:0] c_real;
	logic signed [C_W-1:0] c_imag;

	modport source (output valid, c_real, c_imag, input ready);
	modport sink (input valid, c_real, c_imag, output ready);
endinterface

// ===== hdl/mbe_result_if.sv =====
// Result channel of the Mandelbrot escape-time block: count, inside flag, color.
// Depends on mbe_pkg.
interface mbe_result_if;
	import mbe_pkg::*;

	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   iteration_count;
	logic               inside_res;
	logic [COLOR_W-1:0] color;

	modport source (output valid, iteration_count, inside_res, color, input ready);
	modport sink (input valid, iteration_count, inside_res, color, output ready);
endinterface

// ===== hdl/mbe_cell.sv =====
// One iteration cell of the ring: tests escape and computes z = z*z + c once.
// Depends on mbe_pkg.
module mbe_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbe_pkg::cell_t                cell_in,
	input  logic signed [mbe_pkg::C_W-1:0] c_real,
	input  logic signed [mbe_pkg::C_W-1:0] c_imag,
	input  logic [mbe_pkg::MAX_W-1:0]     max_iterations,
	output mbe_pkg::cell_t                cell_out
);
	import mbe_pkg::*;

	logic [Z_W-1:0]        abs_r;
	logic [Z_W-1:0]        abs_i;
	logic                  big_z;
	logic signed [N_W-1:0] zr_n;
	logic signed [N_W-1:0] zi_n;
	logic signed [P_W-1:0] sq_r;
	logic signed [P_W-1:0] sq_i;
	logic signed [P_W-1:0] cross_p;
	logic [P_W:0]          mag_sum;
	logic signed [P_W:0]   diff;
	logic signed [P_W:0]   diff_sh;
	logic signed [P_W-1:0] cross_sh;
	logic signed [Z_W-1:0] next_r;
	logic signed [Z_W-1:0] next_i;
	logic                  over_limit;
	logic                  escape;
	cell_t                 next;
	cell_t                 cell_q;

	assign abs_r = cell_in.zr[Z_W-1] ? Z_W'(-cell_in.zr) : Z_W'(cell_in.zr);
	assign abs_i = cell_in.zi[Z_W-1] ? Z_W'(-cell_in.zi) : Z_W'(cell_in.zi);
	assign big_z = (abs_r > Z_LIMIT) || (abs_i > Z_LIMIT);

	// The narrow operands are only meaningful when neither component is large.
	assign zr_n    = cell_in.zr[N_W-1:0];
	assign zi_n    = cell_in.zi[N_W-1:0];
	assign sq_r    = zr_n * zr_n;
	assign sq_i    = zi_n * zi_n;
	assign cross_p = zr_n * zi_n;

	assign mag_sum = {1'b0, sq_r} + {1'b0, sq_i};
	assign diff    = {sq_r[P_W-1], sq_r} - {sq_i[P_W-1], sq_i};

	// Arithmetic shifts give the floor; doubling the cross term is one less bit of shift.
	assign diff_sh  = diff >>> FRAC_BITS;
	assign cross_sh = cross_p >>> (FRAC_BITS - 1);
	assign next_r   = diff_sh[Z_W-1:0] + {{(Z_W - C_W){c_real[C_W-1]}}, c_real};
	assign next_i   = cross_sh[Z_W-1:0] + {{(Z_W - C_W){c_imag[C_W-1]}}, c_imag};

	assign over_limit = cell_in.count > {1'b0, max_iterations};
	assign escape     = over_limit || big_z || (mag_sum > SQ_FOUR);

	always_comb begin
		next = cell_in;
		if (cell_in.valid && !cell_in.done) begin
			if (escape) begin
				next.done = 1'b1;
			end else begin
				next.zr    = next_r;
				next.zi    = next_i;
				next.count = cell_in.count + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
			cell_q.done  <= 1'b0;
		end else begin
			cell_q <= next;
		end
	end

	assign cell_out = cell_q;
endmodule

// ===== hdl/mandelbrot_escape_iteration.sv =====
// Channel   Dir  Beat contents                               Handshake
// point     in   c_real, c_imag (signed, FRAC_BITS fraction)   valid/ready
// result    out  iteration_count, inside_res, color          valid/ready
// apb       in   max_iterations, inside_color, outside_color pready tied high
//
// One point is in the ring of iteration cells at a time; each cell does one
// iteration per cycle and hands z on to the next. A finished point keeps circling
// while the result register is full and not read, and moves there when it sits
// in the last cell; the next point can be taken in the cycle after it moves.
// Reset sets the registers to their reset values and empties the ring.
module mandelbrot_escape_iteration (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
	output logic [mbe_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	mbe_point_if.sink                   point,
	mbe_result_if.source                result
);
	import mbe_pkg::*;

	logic [MAX_W-1:0]      max_iter_q;
	logic [COLOR_W-1:0]    in_color_q;
	logic [COLOR_W-1:0]    out_color_q;
	logic signed [C_W-1:0] c_real_q;
	logic signed [C_W-1:0] c_imag_q;
	logic signed [C_W-1:0] c_real_cur;
	logic signed [C_W-1:0] c_imag_cur;
	logic                  busy_q;
	logic                  res_valid_q;
	logic [CNT_W-1:0]      res_count_q;
	logic                  res_inside_q;
	logic [COLOR_W-1:0]    res_color_q;
	logic [1:0]            reg_sel;
	logic                  cfg_write;
	logic                  accept;
	logic                  capture;
	logic                  last_inside;
	cell_t                 feed;
	cell_t                 last;
	cell_t                 ring_in  [NUM_CELLS];
	cell_t                 ring_out [NUM_CELLS];

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			REG_MAX_ITERATIONS: prdata = DATA_W'(max_iter_q);
			REG_INSIDE_COLOR:   prdata = DATA_W'(in_color_q);
			REG_OUTSIDE_COLOR:  prdata = DATA_W'(out_color_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= MAX_ITER_RESET;
			in_color_q  <= INSIDE_COLOR_RESET;
			out_color_q <= OUTSIDE_COLOR_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_MAX_ITERATIONS: max_iter_q  <= pwdata[MAX_W-1:0];
				REG_INSIDE_COLOR:   in_color_q  <= pwdata[COLOR_W-1:0];
				REG_OUTSIDE_COLOR:  out_color_q <= pwdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Ring of iteration cells.
	assign last        = ring_out[NUM_CELLS-1];
	assign accept      = point.valid && point.ready;
	assign capture     = last.valid && last.done && (!res_valid_q || result.ready);
	assign last_inside = last.count > {1'b0, max_iter_q};

	// The first cell iterates in the cycle of the input beat, before c is registered.
	assign c_real_cur = accept ? point.c_real : c_real_q;
	assign c_imag_cur = accept ? point.c_imag : c_imag_q;

	always_comb begin
		feed = last;
		if (capture) begin
			feed.valid = 1'b0;
		end
		if (accept) begin
			feed.valid = 1'b1;
			feed.done  = 1'b0;
			feed.count = '0;
			feed.zr    = {{(Z_W - C_W){point.c_real[C_W-1]}}, point.c_real};
			feed.zi    = {{(Z_W - C_W){point.c_imag[C_W-1]}}, point.c_imag};
		end
	end

	assign ring_in[0] = feed;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign ring_in[i] = ring_out[i-1];
		end
		mbe_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cell_in        (ring_in[i]),
			.c_real         (c_real_cur),
			.c_imag         (c_imag_cur),
			.max_iterations (max_iter_q),
			.cell_out       (ring_out[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (capture) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_real_q <= point.c_real;
			c_imag_q <= point.c_imag;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (capture) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			res_count_q  <= last.count;
			res_inside_q <= last_inside;
			res_color_q  <= last_inside ? in_color_q : out_color_q;
		end
	end

	assign point.ready            = !busy_q;
	assign result.valid           = res_valid_q;
	assign result.iteration_count = res_count_q;
	assign result.inside_res      = res_inside_q;
	assign result.color           = res_color_q;
endmodule

// ===== hdl/mbe_checker.sv =====
// Port-level checks for the Mandelbrot escape-time block, bound to the top level.
// Depends on mbe_pkg and mandelbrot_escape_iteration_macros.svh.
`include "mandelbrot_escape_iteration_macros.svh"

module mbe_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pt_valid,
	input logic                         pt_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [mbe_pkg::CNT_W-1:0]    res_count,
	input logic                         res_inside,
	input logic [mbe_pkg::COLOR_W-1:0]  res_color
);
	import mbe_pkg::*;

	// An inside point has always run at least one iteration.
	`MBE_ASSERT_NOW(a_inside_counted, res_valid && res_inside, res_count != '0, "inside result with zero count")

	// Only one point is worked on at a time.
	`MBE_ASSERT_NEXT(a_one_in_flight, pt_valid && pt_ready, !pt_ready, "input still ready after a beat")

	// The input side closes only because a point was taken.
	`MBE_ASSERT_NOW(a_busy_cause, $fell(pt_ready), $past(pt_valid && pt_ready), "input closed without a beat")

	// A stalled result beat keeps its contents.
	`MBE_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_count) && $stable(res_inside) && $stable(res_color), "stalled result changed")
endmodule

bind mandelbrot_escape_iteration mbe_checker u_mbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pt_valid   (point.valid),
	.pt_ready   (point.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_count  (result.iteration_count),
	.res_inside (result.inside_res),
	.res_color  (result.color)
);

// ===== tb/tb.sv =====
// Self-checking testbench for mandelbrot_escape_iteration: random and directed points
// are checked against an escape-time predictor, and APB register writes are read back.
// Depends on mbe_pkg, mbe_point_if, mbe_result_if and mandelbrot_escape_iteration.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbe_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [C_W-1:0] ONE = C_W'(1) << FRAC_BITS;
	localparam logic signed [C_W-1:0] TWO = C_W'(1) << (FRAC_BITS + 1);
	localparam logic signed [127:0] Z_BOUND = 128'sd1 <<< (FRAC_BITS + 1);
	localparam logic signed [127:0] MAG_SQ_FOUR = 128'sd1 <<< (2 * FRAC_BITS + 2);

	typedef struct {
		logic [CNT_W-1:0]   count;
		logic               in_set;
		logic [COLOR_W-1:0] color;
	} escape_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mbe_point_if  pt();
	mbe_result_if res();

	mandelbrot_escape_iteration u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.point   (pt),
		.result  (res)
	);

	// Register copies kept by the predictor.
	logic [MAX_W-1:0]   max_iter_cfg;
	logic [COLOR_W-1:0] in_color_cfg;
	logic [COLOR_W-1:0] out_color_cfg;

	escape_t pending_q[$];
	int      errors;
	int      points_sent;
	int      results_checked;
	int      limits_used;
	bit      steady;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Escape-time iteration with exact wide arithmetic; the shifts round toward minus infinity.
	function automatic escape_t escape_point(input logic signed [C_W-1:0] cr,
			input logic signed [C_W-1:0] ci);
		logic signed [127:0] c_r, c_i, zr, zi, sq_r, sq_i, nr, ni;
		int      count;
		escape_t e;
		c_r = cr;
		c_i = ci;
		zr = c_r;
		zi = c_i;
		count = 0;
		while (count <= int'(max_iter_cfg)) begin
			if (zr > Z_BOUND || zr < -Z_BOUND || zi > Z_BOUND || zi < -Z_BOUND)
				break;
			sq_r = zr * zr;
			sq_i = zi * zi;
			if (sq_r + sq_i > MAG_SQ_FOUR)
				break;
			nr = ((sq_r - sq_i) >>> FRAC_BITS) + c_r;
			// The imaginary part uses the real part from before this iteration.
			ni = ((zr * zi) >>> (FRAC_BITS - 1)) + c_i;
			zr = nr;
			zi = ni;
			count++;
		end
		e.count = count[CNT_W-1:0];
		e.in_set = (count > int'(max_iter_cfg));
		e.color = e.in_set ? in_color_cfg : out_color_cfg;
		return e;
	endfunction

	function automatic int pick_gap(input int longest);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, longest);
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_MAX_ITERATIONS: return DATA_W'(max_iter_cfg);
			REG_INSIDE_COLOR:   return DATA_W'(in_color_cfg);
			REG_OUTSIDE_COLOR:  return DATA_W'(out_color_cfg);
			default:            return '0;
		endcase
	endfunction

	task automatic read_reg(input logic [1:0] idx);
		logic [DATA_W-1:0] data;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (data !== reg_value(idx))
			report_mismatch($sformatf("register %0d reads %h, expected %h",
				idx, data, reg_value(idx)));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAX_ITERATIONS: max_iter_cfg = value[MAX_W-1:0];
			REG_INSIDE_COLOR:   in_color_cfg = value[COLOR_W-1:0];
			REG_OUTSIDE_COLOR:  out_color_cfg = value[COLOR_W-1:0];
			default: ;
		endcase
		if (idx == REG_MAX_ITERATIONS)
			limits_used++;
		if (idx != REG_UNUSED)
			read_reg(idx);
	endtask

	// Valid stays high across back-to-back beats and is only dropped ahead of a gap.
	task automatic send_point(input logic signed [C_W-1:0] cr, input logic signed [C_W-1:0] ci);
		int      gap;
		escape_t e;
		gap = pick_gap(40);
		e = escape_point(cr, ci);
		@(negedge clk);
		if (gap > 0) begin
			pt.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pt.valid <= 1'b1;
		pt.c_real <= cr;
		pt.c_imag <= ci;
		do @(posedge clk); while (!pt.ready);
		pending_q.push_back(e);
		points_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		pt.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [C_W-1:0] edge_value();
		case ($urandom_range(0, 8))
			0: return 0;
			1: return TWO;
			2: return -TWO;
			3: return TWO + 1;
			4: return -TWO - 1;
			5: return 32'sh7FFF_FFFF;
			6: return 32'sh8000_0000;
			7: return ONE;
			default: return -ONE;
		endcase
	endfunction

	task automatic pick_point(output logic signed [C_W-1:0] cr, output logic signed [C_W-1:0] ci);
		case ($urandom_range(0, 9))
			0, 1: begin
				cr = $urandom;
				ci = $urandom;
			end
			2, 3: begin
				cr = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
				ci = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
			end
			9: begin
				cr = edge_value();
				ci = edge_value();
			end
			default: begin
				// Real part from -2 to 0.5 and imaginary part within 1.25: most long orbits live here.
				cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
				ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
			end
		endcase
	endtask

	always @(posedge clk) begin : result_check
		escape_t e;
		if (arst_n && res.valid && res.ready) begin
			results_checked++;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result beat count=%0d with no point pending",
					res.iteration_count));
			end else begin
				e = pending_q.pop_front();
				if (res.iteration_count !== e.count)
					report_mismatch($sformatf("iteration_count %0d, expected %0d",
						res.iteration_count, e.count));
				if (res.inside_res !== e.in_set)
					report_mismatch($sformatf("inside_res %b, expected %b",
						res.inside_res, e.in_set));
				if (res.color !== e.color)
					report_mismatch($sformatf("color %h, expected %h", res.color, e.color));
			end
		end
	end

	initial begin : result_ready_drive
		int stall_left;
		stall_left = 0;
		res.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !steady && $urandom_range(0, 5) == 0)
				stall_left = pick_gap(60);
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic test_reset_values();
		max_iter_cfg = MAX_ITER_RESET;
		in_color_cfg = INSIDE_COLOR_RESET;
		out_color_cfg = OUTSIDE_COLOR_RESET;
		read_reg(REG_MAX_ITERATIONS);
		read_reg(REG_INSIDE_COLOR);
		read_reg(REG_OUTSIDE_COLOR);
	endtask

	task automatic test_field_extremes();
		send_point(0, 0);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh8000_0000, 0);
		send_point(0, 32'sh7FFF_FFFF);
		// At -2 the orbit sits on |z|^2 == 4 forever, which does not count as escape.
		send_point(-TWO, 0);
		send_point(TWO, 0);
		send_point(0, TWO);
		send_point(TWO + 1, 0);
		send_point(0, -TWO - 1);
		send_point(-ONE, 0);
		send_point(0, ONE);
		send_point(ONE >>> 2, 0);
		send_point(-32'sh0C00_0000, 32'sh0199_999A);
		send_point(32'shF876_5433, 32'sh0ABC_DEF1);
		send_point(1, -1);
		wait_idle();
	endtask

	task automatic test_zero_limit();
		write_reg(REG_MAX_ITERATIONS, 32'd0);
		send_point(0, 0);
		send_point(TWO + 1, 0);
		send_point(-ONE, ONE);
		wait_idle();
	endtask

	task automatic test_long_limit();
		write_reg(REG_MAX_ITERATIONS, 32'd1023);
		send_point(0, 0);
		send_point(-TWO, 0);
		send_point(ONE >>> 2, 0);
		wait_idle();
	endtask

	task automatic test_register_masking();
		write_reg(REG_MAX_ITERATIONS, 32'hFFFF_FFFF);
		write_reg(REG_INSIDE_COLOR, 32'hFFFF_FFFF);
		write_reg(REG_OUTSIDE_COLOR, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'h5A5A_5A5A);
		read_reg(REG_MAX_ITERATIONS);
		read_reg(REG_INSIDE_COLOR);
		read_reg(REG_OUTSIDE_COLOR);
		write_reg(REG_MAX_ITERATIONS, 32'hABCD_FC01);
		write_reg(REG_INSIDE_COLOR, 32'hFF12_3456);
		write_reg(REG_OUTSIDE_COLOR, 32'h0165_4321);
		send_point(0, 0);
		send_point(ONE, ONE);
		wait_idle();
	endtask

	task automatic test_random_mix();
		int                    limits[6] = '{100, 1023, 1, 0, 37, 255};
		int                    lengths[6] = '{200, 30, 60, 30, 150, 130};
		logic signed [C_W-1:0] cr, ci;
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_MAX_ITERATIONS, DATA_W'(limits[p]));
			write_reg(REG_INSIDE_COLOR, $urandom);
			write_reg(REG_OUTSIDE_COLOR, $urandom);
			for (int i = 0; i < lengths[p]; i++) begin
				// The first fifth of each phase sends with no input gaps, and no new result stalls start.
				steady = (i < lengths[p] / 5);
				pick_point(cr, ci);
				send_point(cr, ci);
			end
			steady = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		errors = 0;
		points_sent = 0;
		results_checked = 0;
		limits_used = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pt.valid = 1'b0;
		pt.c_real = '0;
		pt.c_imag = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_field_extremes();
		test_zero_limit();
		test_long_limit();
		test_register_masking();
		test_random_mix();

		wait_idle();
		repeat (int'(max_iter_cfg) + 8) @(posedge clk);
		$display("Sent %0d points and checked %0d escape results under %0d limit settings,",
			points_sent, results_checked, limits_used);
		$display("including the zero and largest limits, masked writes and random stalls.");
		if (errors == 0)
			$display("mandelbrot_escape_iteration test passed");
		else
			$display("mandelbrot_escape_iteration test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run stopped by the watchdog with %0d results pending.", pending_q.size());
		$display("mandelbrot_escape_iteration test failed");
		$finish;
	end

endmodule
